/* hdl/bfdh_pkg.sv */
package bfdh_pkg;

    localparam int HASH_W     = 64;
    localparam int HALF_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int BITS_W     = 17;
    localparam int HASHES_W   = 6;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 17;

    localparam int DEF_MAX_BITS   = 65536;
    localparam int DEF_MAX_HASHES = 32;

    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF29CE484222325;
    // fnv prime is 2^40 + 0x1b3
    localparam int                FNV_SHIFT = 40;

    localparam logic [BITS_W-1:0]   BIT_COUNT_RST  = 17'd65536;
    localparam logic [HASHES_W-1:0] HASH_COUNT_RST = 6'd7;

    localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT = 8'd1;

    // operand of the serial remainder unit
    localparam logic [1:0] SEL_H1   = 2'd0;
    localparam logic [1:0] SEL_H2   = 2'd1;
    localparam logic [1:0] SEL_ONES = 2'd2;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    typedef struct packed {
        logic       clr_step;
        logic       load_item;
        logic       mix;
        logic       fin_start;
        logic       rem_step;
        logic       rem_last;
        logic [1:0] sel;
        logic       rem_load;
        logic [1:0] load_sel;
        logic       probe;
        logic       fix;
        logic       out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic probes_done;
        logic out_free;
    } dp_status_t;

endpackage

/* hdl/bfdh_ctrl.sv */
module bfdh_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tlast,
    input  logic                   s_has_byte,
    output logic                   s_axis_tready,
    output bfdh_pkg::ctrl_cmd_t    cmd,
    input  bfdh_pkg::dp_status_t   status
);
    import bfdh_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_MIX    = 3'd2;
    localparam logic [2:0] ST_START  = 3'd3;
    localparam logic [2:0] ST_REM    = 3'd4;
    localparam logic [2:0] ST_PROBE  = 3'd5;
    localparam logic [2:0] ST_FIX    = 3'd6;
    localparam logic [2:0] ST_RESULT = 3'd7;

    localparam int STEP_W = $clog2(HASH_W);

    logic [2:0]        state_reg, state_next;
    logic              last_reg, last_next;
    logic [1:0]        sel_reg, sel_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb begin
        state_next    = state_reg;
        last_next     = last_reg;
        sel_next      = sel_reg;
        step_next     = step_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    cmd.load_item = 1'b1;
                    last_next     = s_axis_tlast;
                    if (s_has_byte) begin
                        state_next = ST_MIX;
                    end else if (s_axis_tlast) begin
                        state_next = ST_START;
                    end
                end
            end
            ST_MIX: begin
                cmd.mix = 1'b1;
                state_next = last_reg ? ST_START : ST_IDLE;
            end
            ST_START: begin
                cmd.fin_start = 1'b1;
                sel_next      = SEL_H1;
                step_next     = '0;
                state_next    = ST_REM;
            end
            ST_REM: begin
                cmd.rem_step = 1'b1;
                cmd.sel      = sel_reg;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(HASH_W - 1)) begin
                    cmd.rem_last = 1'b1;
                    unique case (sel_reg)
                        SEL_H1: begin
                            cmd.rem_load = 1'b1;
                            cmd.load_sel = SEL_H2;
                            sel_next     = SEL_H2;
                        end
                        SEL_H2: begin
                            cmd.rem_load = 1'b1;
                            cmd.load_sel = SEL_ONES;
                            sel_next     = SEL_ONES;
                        end
                        default: begin
                            state_next = status.probes_done ? ST_RESULT : ST_PROBE;
                        end
                    endcase
                end
            end
            ST_PROBE: begin
                cmd.probe  = 1'b1;
                state_next = ST_FIX;
            end
            ST_FIX: begin
                cmd.fix    = 1'b1;
                state_next = status.probes_done ? ST_RESULT : ST_PROBE;
            end
            ST_RESULT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            last_reg  <= 1'b0;
            sel_reg   <= SEL_H1;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
            sel_reg   <= sel_next;
            step_reg  <= step_next;
        end
    end

endmodule

/* hdl/bfdh_datapath.sv */
module bfdh_datapath #(
    parameter int MAX_BITS   = bfdh_pkg::DEF_MAX_BITS,
    parameter int MAX_HASHES = bfdh_pkg::DEF_MAX_HASHES
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bfdh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bfdh_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [bfdh_pkg::BYTE_W-1:0]         s_key_byte,
    input  logic                                s_action,
    input  logic                                s_has_byte,
    input  bfdh_pkg::ctrl_cmd_t                 cmd,
    output bfdh_pkg::dp_status_t                status,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic                                m_found,
    output logic                                m_was_insert
);
    import bfdh_pkg::*;

    localparam int AW = $clog2(MAX_BITS);
    localparam int KW = $clog2(MAX_HASHES + 1);

    logic [BITS_W-1:0]   bit_count_reg, bit_count_next;
    logic [HASHES_W-1:0] hash_count_reg, hash_count_next;
    logic [HASH_W-1:0]   hash_reg, hash_next;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;
    logic                m_valid_reg, m_valid_next;

    logic                action_reg, action_next;
    logic [HASH_W-1:0]   acc_reg, acc_next;
    logic                carry_reg, carry_next;
    logic [HALF_W-1:0]   h2_reg, h2_next;
    logic [BITS_W-1:0]   m_reg, m_next;
    logic [KW-1:0]       k_reg, k_next;
    logic [KW-1:0]       cnt_reg, cnt_next;
    logic [HASH_W-1:0]   div_reg, div_next;
    logic [BITS_W-1:0]   rem_reg, rem_next;
    logic [BITS_W-1:0]   r_reg, r_next;
    logic [BITS_W-1:0]   d_reg, d_next;
    logic [BITS_W-1:0]   w_reg, w_next;
    logic                hit_reg, hit_next;
    logic                found_reg, found_next;
    logic                was_ins_reg, was_ins_next;
    logic                rd_bit_reg;

    logic                mem [MAX_BITS];

    logic [BITS_W-1:0]   m_eff;
    logic [KW-1:0]       k_eff;
    logic [BITS_W:0]     rem_shift;
    logic [BITS_W-1:0]   rem_step_val;
    logic [BITS_W:0]     w_plus;
    logic [BITS_W:0]     mod_sum;
    logic [BITS_W:0]     mod_diff;
    logic [HASH_W:0]     acc_sum;
    logic [AW-1:0]       probe_addr;

    // x * (2^40 + 0x1b3) mod 2^64
    function automatic logic [HASH_W-1:0] fnv_mul(input logic [HASH_W-1:0] x);
        fnv_mul = (x << FNV_SHIFT) + (x << 8) + (x << 7) + (x << 5)
                + (x << 4) + (x << 1) + x;
    endfunction

    function automatic logic [HASH_W-1:0] rem_operand(input logic [1:0] sel,
                                                      input logic [HALF_W-1:0] h2);
        unique case (sel)
            SEL_H2:   rem_operand = {{(HASH_W-HALF_W){1'b0}}, h2};
            SEL_ONES: rem_operand = '1;
            default:  rem_operand = '0;
        endcase
    endfunction

    assign cfg_ready  = 1'b1;
    assign probe_addr = AW'(r_reg);

    always_comb begin
        if (bit_count_reg == '0) begin
            m_eff = BITS_W'(1);
        end else if (32'(bit_count_reg) > 32'(MAX_BITS)) begin
            m_eff = BITS_W'(MAX_BITS);
        end else begin
            m_eff = bit_count_reg;
        end
        if (32'(hash_count_reg) > 32'(MAX_HASHES)) begin
            k_eff = KW'(MAX_HASHES);
        end else begin
            k_eff = KW'(hash_count_reg);
        end
    end

    // one restoring step, msb of the dividend first
    always_comb begin
        rem_shift = {rem_reg, div_reg[HASH_W-1]};
        if (rem_shift >= {1'b0, m_reg}) begin
            rem_step_val = BITS_W'(rem_shift - {1'b0, m_reg});
        end else begin
            rem_step_val = rem_shift[BITS_W-1:0];
        end
        w_plus = {1'b0, rem_step_val} + 1'b1;
    end

    always_comb begin
        acc_sum = {1'b0, acc_reg} + {{(HASH_W-HALF_W+1){1'b0}}, h2_reg};
        mod_sum = {1'b0, r_reg} + {1'b0, d_reg};
        if (mod_sum >= {1'b0, m_reg}) begin
            mod_sum = mod_sum - {1'b0, m_reg};
        end
        // wrap of the 64-bit probe sum drops 2^64, i.e. w modulo m
        if (r_reg >= w_reg) begin
            mod_diff = {1'b0, r_reg} - {1'b0, w_reg};
        end else begin
            mod_diff = {1'b0, r_reg} + {1'b0, m_reg} - {1'b0, w_reg};
        end
    end

    always_comb begin
        bit_count_next  = bit_count_reg;
        hash_count_next = hash_count_reg;
        hash_next       = hash_reg;
        clr_addr_next   = clr_addr_reg;
        m_valid_next    = m_valid_reg;
        action_next     = action_reg;
        acc_next        = acc_reg;
        carry_next      = carry_reg;
        h2_next         = h2_reg;
        m_next          = m_reg;
        k_next          = k_reg;
        cnt_next        = cnt_reg;
        div_next        = div_reg;
        rem_next        = rem_reg;
        r_next          = r_reg;
        d_next          = d_reg;
        w_next          = w_reg;
        hit_next        = hit_reg;
        found_next      = found_reg;
        was_ins_next    = was_ins_reg;

        if (cfg_valid) begin
            if (cfg_index == REG_BIT_COUNT) begin
                bit_count_next = cfg_data[BITS_W-1:0];
            end else if (cfg_index == REG_HASH_COUNT) begin
                hash_count_next = cfg_data[HASHES_W-1:0];
            end
        end

        if (cmd.clr_step) begin
            clr_addr_next = clr_addr_reg + 1'b1;
        end

        if (cmd.load_item) begin
            action_next = s_action;
            if (s_has_byte) begin
                hash_next = hash_reg ^ {{(HASH_W-BYTE_W){1'b0}}, s_key_byte};
            end
        end
        if (cmd.mix) begin
            hash_next = fnv_mul(hash_reg);
        end

        if (cmd.fin_start) begin
            acc_next  = hash_reg;
            h2_next   = hash_reg[HASH_W-1:HALF_W] ^ hash_reg[HALF_W-1:0] | HALF_W'(1);
            hash_next = FNV_BASIS;
            m_next    = m_eff;
            k_next    = k_eff;
            cnt_next  = '0;
            hit_next  = 1'b1;
            div_next  = hash_reg;
            rem_next  = '0;
        end

        if (cmd.rem_step) begin
            div_next = div_reg << 1;
            rem_next = rem_step_val;
            if (cmd.rem_last) begin
                unique case (cmd.sel)
                    SEL_H1: r_next = rem_step_val;
                    SEL_H2: d_next = rem_step_val;
                    default: begin
                        w_next = (w_plus == {1'b0, m_reg}) ? '0 : w_plus[BITS_W-1:0];
                    end
                endcase
            end
        end
        if (cmd.rem_load) begin
            div_next = rem_operand(cmd.load_sel, h2_reg);
            rem_next = '0;
        end

        if (cmd.probe) begin
            acc_next   = acc_sum[HASH_W-1:0];
            carry_next = acc_sum[HASH_W];
            r_next     = mod_sum[BITS_W-1:0];
            cnt_next   = cnt_reg + 1'b1;
        end
        if (cmd.fix) begin
            if (carry_reg) begin
                r_next = mod_diff[BITS_W-1:0];
            end
            if (action_reg == ACT_QUERY && !rd_bit_reg) begin
                hit_next = 1'b0;
            end
        end

        if (cmd.out_load) begin
            m_valid_next = 1'b1;
            found_next   = (action_reg == ACT_QUERY) ? hit_reg : 1'b0;
            was_ins_next = (action_reg == ACT_INSERT);
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_count_reg  <= BIT_COUNT_RST;
            hash_count_reg <= HASH_COUNT_RST;
            hash_reg       <= FNV_BASIS;
            clr_addr_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            bit_count_reg  <= bit_count_next;
            hash_count_reg <= hash_count_next;
            hash_reg       <= hash_next;
            clr_addr_reg   <= clr_addr_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        action_reg  <= action_next;
        acc_reg     <= acc_next;
        carry_reg   <= carry_next;
        h2_reg      <= h2_next;
        m_reg       <= m_next;
        k_reg       <= k_next;
        cnt_reg     <= cnt_next;
        div_reg     <= div_next;
        rem_reg     <= rem_next;
        r_reg       <= r_next;
        d_reg       <= d_next;
        w_reg       <= w_next;
        hit_reg     <= hit_next;
        found_reg   <= found_next;
        was_ins_reg <= was_ins_next;
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            mem[clr_addr_reg] <= 1'b0;
        end else if (cmd.probe && action_reg == ACT_INSERT) begin
            mem[probe_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.probe) begin
            rd_bit_reg <= mem[probe_addr];
        end
    end

    assign status.clr_last    = (clr_addr_reg == AW'(MAX_BITS - 1));
    assign status.probes_done = (cnt_reg == k_reg);
    assign status.out_free    = !m_valid_reg || m_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_found       = found_reg;
    assign m_was_insert  = was_ins_reg;

    a_probe_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.probe |-> (r_reg < m_reg) && (d_reg < m_reg) && (w_reg < m_reg))
        else $error("probe residue not reduced below modulus");

    a_modulus_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin_start |=> (m_reg != '0) && (32'(m_reg) <= 32'(MAX_BITS)))
        else $error("latched modulus out of range");

    a_no_probe_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.probe |-> !cmd.clr_step)
        else $error("probe issued during clearing pass");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_axis_tready))
        else $error("result loaded over an unsent result");

    a_hash_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin_start |=> (hash_reg == FNV_BASIS) && (acc_reg == $past(hash_reg)))
        else $error("running hash not restarted at end of key");

endmodule

/* hdl/bloom_filter_fnv_double_hash.sv */
// bloom filter over a bit store, keys hashed with 64-bit fnv-1a and double hashing.
// s_axis carries one key byte per word; tlast marks the final word of a key and
// tuser bit 0 on that word picks insert (0) or query (1). tuser bit 1 says the
// byte is valid; an empty key is a single last word with that bit low.
// m_axis returns one word per key: tdata bit 0 is found (queries only), tuser is
// was_insert. cfg writes index 0 (bit_count) or 1 (hash_count); cfg_ready is
// always high, other indexes are dropped.
// a byte word is accepted, then the fnv multiply runs. the last word of a key then
// latches the hashes and runs the bit-serial remainder unit (h1, h2 and 2^64 each
// reduced modulo bit_count, one bit a cycle), then each probe takes a probe and a fix
// state through the single-port bit store, then the result goes into the output
// register; the fnv multiply is skipped when the last word carries no byte.
// after reset the bit store is swept clear, one bit a cycle, with s_axis_tready low.
// a stalled m_axis holds the result in its register; the block keeps taking words
// but waits in its result state, taking no new word, once the next result is ready.
module bloom_filter_fnv_double_hash #(
    parameter int MAX_BITS   = bfdh_pkg::DEF_MAX_BITS,
    parameter int MAX_HASHES = bfdh_pkg::DEF_MAX_HASHES
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // key_byte
    input  logic [1:0]                        s_axis_tuser,   // action, has_byte
    input  logic                              s_axis_tlast,   // key_last
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata,   // found, zero fill
    output logic                              m_axis_tuser,   // was_insert
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bfdh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bfdh_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bfdh_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       found;

    bfdh_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .s_has_byte    (s_axis_tuser[1]),
        .s_axis_tready (s_axis_tready),
        .cmd           (cmd),
        .status        (status)
    );

    bfdh_datapath #(
        .MAX_BITS   (MAX_BITS),
        .MAX_HASHES (MAX_HASHES)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_key_byte    (s_axis_tdata),
        .s_action      (s_axis_tuser[0]),
        .s_has_byte    (s_axis_tuser[1]),
        .cmd           (cmd),
        .status        (status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_found       (found),
        .m_was_insert  (m_axis_tuser)
    );

    assign m_axis_tdata = {7'b0, found};

endmodule

/* sim/bloom_filter_fnv_double_hash_tb.sv */
`timescale 1ns / 100ps

module bloom_filter_fnv_double_hash_tb;

    import bfdh_pkg::*;

    localparam logic [HASH_W-1:0]     HASH_MULT     = 64'h0000_0100_0000_01B3;
    localparam logic [CFG_IDX_W-1:0]  REG_UNUSED_LO = 8'd2;
    localparam logic [CFG_IDX_W-1:0]  REG_UNUSED_HI = 8'd255;
    localparam logic [CFG_DATA_W-1:0] BITS_OVER     = 17'h1FFFF;
    localparam logic [CFG_DATA_W-1:0] HASHES_OVER   = 17'd63;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int SETTLE_WAIT  = 8;
    localparam int TAIL_WAIT    = 300;
    localparam int HOLD_CYCLES  = 2500;
    localparam int POOL_SIZE    = 64;
    localparam int KEY_MAX      = 12;
    localparam int PHASE_WORDS  = 210;

    typedef struct packed {
        logic found;
        logic was_insert;
    } ack_t;

    // mirror of the filter: running fnv hash, bit store and the two registers
    class bloom_mirror;
        logic [BITS_W-1:0]   bits_reg;
        logic [HASHES_W-1:0] hashes_reg;
        logic [HASH_W-1:0]   fnv_state;
        bit                  store_bits [0:DEF_MAX_BITS-1];
        ack_t                pending_acks [$];
        int                  errors;

        function new();
            bits_reg   = BIT_COUNT_RST;
            hashes_reg = HASH_COUNT_RST;
            fnv_state  = FNV_BASIS;
            foreach (store_bits[i]) store_bits[i] = 1'b0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_BIT_COUNT) begin
                bits_reg = val;
            end else if (idx == REG_HASH_COUNT) begin
                hashes_reg = val[HASHES_W-1:0];
            end
        endfunction

        function void absorb_word(logic action, logic [7:0] kb, logic has, logic last);
            logic [HASH_W-1:0] h1;
            logic [HASH_W-1:0] h2;
            logic [HASH_W-1:0] modulus;
            logic [HASH_W-1:0] step_i;
            logic [HASH_W-1:0] pos;
            int                probes;
            logic              hit;
            ack_t              ack;
            hit = 1'b1;
            if (has) begin
                fnv_state = (fnv_state ^ {56'd0, kb}) * HASH_MULT;
            end
            if (!last) return;
            h1 = fnv_state;
            h2 = {32'd0, h1[63:32] ^ h1[31:0]} | 64'd1;
            if (bits_reg == 0) begin
                modulus = 64'd1;
            end else if (bits_reg > DEF_MAX_BITS) begin
                modulus = 64'(DEF_MAX_BITS);
            end else begin
                modulus = {47'd0, bits_reg};
            end
            probes = (hashes_reg > DEF_MAX_HASHES) ? DEF_MAX_HASHES : int'(hashes_reg);
            for (int i = 0; i < probes; i++) begin
                step_i = 64'(i);
                pos = (h1 + step_i * h2) % modulus;
                if (action == ACT_INSERT) begin
                    store_bits[pos[15:0]] = 1'b1;
                end else if (!store_bits[pos[15:0]]) begin
                    hit = 1'b0;
                end
            end
            fnv_state = FNV_BASIS;
            ack.was_insert = (action == ACT_INSERT);
            ack.found      = (action == ACT_QUERY) && hit;
            pending_acks.push_back(ack);
        endfunction

        function void match_ack(logic found, logic was_insert);
            ack_t want;
            if (pending_acks.size() == 0) begin
                $display("%0t: result with none expected, found=%0b was_insert=%0b",
                         $time, found, was_insert);
                errors++;
                return;
            end
            want = pending_acks.pop_front();
            if (found !== want.found) begin
                $display("%0t: found mismatch, expected %0b actual %0b",
                         $time, want.found, found);
                errors++;
            end
            if (was_insert !== want.was_insert) begin
                $display("%0t: was_insert mismatch, expected %0b actual %0b",
                         $time, want.was_insert, was_insert);
                errors++;
            end
        endfunction

        function int waiting();
            return pending_acks.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;   // key_byte
    logic [1:0]            s_axis_tuser;   // action, has_byte
    logic                  s_axis_tlast;   // key_last
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [7:0]            m_axis_tdata;   // found, zero fill
    logic                  m_axis_tuser;   // was_insert
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bloom_mirror mirror = new();

    logic [7:0] key_pool [0:POOL_SIZE-1][0:KEY_MAX-1];
    int         pool_len [0:POOL_SIZE-1];
    int         pool_fill = 0;
    bit         hold_req  = 1'b0;
    int         cycle_count;

    bloom_filter_fnv_double_hash u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    function automatic int pick_gap(bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    task automatic send_word(logic action, logic [7:0] kb, logic has, logic last, int gap);
        if (gap > 0) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= kb;
        s_axis_tuser  <= {has, action};
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        mirror.absorb_word(action, kb, has, last);
    endtask

    task automatic put(logic action, logic [7:0] kb, logic has, logic last);
        send_word(action, kb, has, last, $urandom_range(0, 1));
    endtask

    // a byte word still in flight gives no result, so wait for every pending result, then the given extra wait
    task automatic settle(int extra);
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (mirror.waiting() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        mirror.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // whole keys with random content, sometimes re-querying an inserted key
    task automatic stream_keys(int words);
        int         sent;
        int         len;
        int         slot;
        logic       action;
        bit         tail_empty;
        bit         steady;
        logic [7:0] key [0:KEY_MAX-1];
        sent = 0;
        while (sent < words) begin
            action = logic'($urandom_range(0, 1));
            steady = ($urandom_range(0, 4) == 0);
            if (action == ACT_QUERY && pool_fill > 0 && $urandom_range(0, 1) == 1) begin
                slot = $urandom_range(0, pool_fill - 1);
                len  = pool_len[slot];
                for (int j = 0; j < len; j++) key[j] = key_pool[slot][j];
            end else begin
                len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6)
                                                 : $urandom_range(0, KEY_MAX);
                for (int j = 0; j < len; j++) key[j] = 8'($urandom_range(0, 255));
            end
            tail_empty = (len == 0) || ($urandom_range(0, 6) == 0);
            for (int j = 0; j < len; j++) begin
                if ($urandom_range(0, 19) == 0) begin
                    // stray word with no byte, dropped by the block
                    send_word(logic'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              1'b0, 1'b0, pick_gap(steady));
                end
                send_word((j == len - 1) ? action : logic'($urandom_range(0, 1)), key[j],
                          1'b1, (j == len - 1) && !tail_empty, pick_gap(steady));
            end
            if (tail_empty) begin
                send_word(action, 8'($urandom_range(0, 255)), 1'b0, 1'b1,
                          pick_gap(steady));
            end
            sent += len + int'(tail_empty);
            if (action == ACT_INSERT) begin
                if (pool_fill < POOL_SIZE) begin
                    slot = pool_fill;
                    pool_fill++;
                end else begin
                    slot = $urandom_range(0, POOL_SIZE - 1);
                end
                pool_len[slot] = len;
                for (int j = 0; j < len; j++) key_pool[slot][j] = key[j];
            end
        end
    endtask

    // result side: random stall pattern, plus one long hold-off on request
    initial begin
        bit ready_now;
        int run_left;
        ready_now = 1'b1;
        run_left  = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                run_left = 0;
            end
            if (run_left == 0) begin
                ready_now = ($urandom_range(0, 2) != 0);
                if (ready_now) begin
                    run_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 400)
                                                           : $urandom_range(1, 20);
                end else begin
                    run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                           : $urandom_range(1, 3);
                end
            end
            m_axis_tready <= ready_now;
            run_left--;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            mirror.match_ack(m_axis_tdata[0], m_axis_tuser);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // bit store is swept clear after reset
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);

        // reset settings: byte extremes, stray word, empty key, key closed by an empty word
        put(ACT_QUERY, 8'h00, 1'b1, 1'b0);
        put(ACT_INSERT, 8'hFF, 1'b1, 1'b1);
        put(ACT_INSERT, 8'h00, 1'b1, 1'b0);
        put(ACT_QUERY, 8'hFF, 1'b1, 1'b1);
        put(ACT_QUERY, 8'hA5, 1'b0, 1'b0);
        put(ACT_QUERY, 8'h00, 1'b1, 1'b1);
        put(ACT_INSERT, 8'h00, 1'b0, 1'b1);
        put(ACT_QUERY, 8'hFF, 1'b0, 1'b1);
        put(ACT_QUERY, 8'h7F, 1'b1, 1'b0);
        put(ACT_INSERT, 8'h80, 1'b0, 1'b1);
        put(ACT_QUERY, 8'h7F, 1'b1, 1'b1);
        settle(SETTLE_WAIT);

        // no probes: query hits, insert leaves the store alone
        write_reg(REG_HASH_COUNT, '0);
        put(ACT_QUERY, 8'h55, 1'b1, 1'b1);
        put(ACT_INSERT, 8'h55, 1'b1, 1'b1);
        settle(SETTLE_WAIT);

        // registers change in the middle of a key
        write_reg(REG_HASH_COUNT, HASHES_OVER);
        put(ACT_QUERY, 8'h12, 1'b1, 1'b0);
        settle(SETTLE_WAIT);
        write_reg(REG_BIT_COUNT, BITS_OVER);
        put(ACT_INSERT, 8'h34, 1'b1, 1'b1);
        put(ACT_INSERT, 8'h12, 1'b1, 1'b0);
        put(ACT_QUERY, 8'h34, 1'b1, 1'b1);
        settle(SETTLE_WAIT);

        // writes outside the register list are dropped; modulus of zero acts as one
        write_reg(REG_UNUSED_LO, 17'd5);
        write_reg(REG_UNUSED_HI, '0);
        write_reg(REG_BIT_COUNT, '0);
        put(ACT_INSERT, 8'h01, 1'b1, 1'b1);
        put(ACT_QUERY, 8'h02, 1'b1, 1'b1);
        settle(SETTLE_WAIT);
        write_reg(REG_BIT_COUNT, 17'd1);
        write_reg(REG_HASH_COUNT, 17'd1);
        put(ACT_QUERY, 8'h03, 1'b1, 1'b1);
        settle(SETTLE_WAIT);

        write_reg(REG_BIT_COUNT, 17'd64);
        write_reg(REG_HASH_COUNT, 17'd3);
        stream_keys(PHASE_WORDS);
        settle(SETTLE_WAIT);

        write_reg(REG_BIT_COUNT, 17'd1000);
        write_reg(REG_HASH_COUNT, 17'd1);
        stream_keys(PHASE_WORDS);
        settle(SETTLE_WAIT);

        // hold the result side off while keys keep coming
        write_reg(REG_BIT_COUNT, 17'd65536);
        write_reg(REG_HASH_COUNT, 17'd32);
        hold_req = 1'b1;
        stream_keys(PHASE_WORDS);
        settle(SETTLE_WAIT);

        write_reg(REG_BIT_COUNT, 17'd700);
        write_reg(REG_HASH_COUNT, 17'd7);
        stream_keys(PHASE_WORDS);
        settle(SETTLE_WAIT);

        write_reg(REG_BIT_COUNT, 17'd2);
        write_reg(REG_HASH_COUNT, HASHES_OVER);
        stream_keys(PHASE_WORDS);
        settle(TAIL_WAIT);

        if (mirror.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
